### rtl/digit_pattern_matcher_macros.svh
// ----------------------------------------------------------------------------
// digit pattern matcher assertion macros
// Shared concurrent assertion forms for the matcher modules.
// ----------------------------------------------------------------------------
`ifndef DIGIT_PATTERN_MATCHER_MACROS_SVH
`define DIGIT_PATTERN_MATCHER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DPM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("dpm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DPM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("dpm assertion failed");

`endif

### rtl/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg
// Types, codes and defaults shared by the digit pattern matcher modules.
// ----------------------------------------------------------------------------
package dpm_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int ALPHABET_DEF  = 10;
	localparam int NODE_OUT_W    = 10;

	typedef enum logic [2:0] {
		OPC_CLEAR   = 3'd0,
		OPC_INSERT  = 3'd1,
		OPC_END     = 3'd2,
		OPC_BUILD   = 3'd3,
		OPC_RESTART = 3'd4,
		OPC_MATCH   = 3'd5
	} opc_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DIGIT = 2'd2,
		ST_PHASE = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] digit;
	} in_t;

	typedef struct packed {
		status_t               status;
		logic                  match_here;
		logic                  matched_any;
		logic [NODE_OUT_W-1:0] node;
	} out_t;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_ERROR,
		OP_INIT_ROOT,
		OP_CLEAR,
		OP_RESTART,
		OP_RD_CURSOR,
		OP_RD_CURRENT,
		OP_INS_EDGE,
		OP_INS_FOLLOW,
		OP_INS_NEW,
		OP_END,
		OP_MAT_STEP,
		OP_MAT_OUT,
		OP_BLD_START,
		OP_BLD_POP,
		OP_BLD_DONE,
		OP_BLD_V,
		OP_BLD_LK,
		OP_BLD_ROW,
		OP_BLD_DIGIT,
		OP_BLD_WB,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       built;
		logic       digit_bad;
		logic       child_zero;
		logic       full;
		logic       bfs_more;
		logic       digit_last;
	} dp_stat_t;

endpackage

### rtl/dpm_datapath.sv
// ----------------------------------------------------------------------------
// dpm_datapath
// Node row memory, failure link and bfs queue memories, automaton registers.
// ----------------------------------------------------------------------------
`include "digit_pattern_matcher_macros.svh"

module dpm_datapath
	import dpm_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int ALPHABET  = ALPHABET_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_t      in_data,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output out_t     out_data
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int DIG_W  = $clog2(ALPHABET);

	typedef struct packed {
		logic                             term;
		logic                             outb;
		logic [ALPHABET-1:0][NODE_W-1:0]  nxt;
	} row_t;

	row_t              row_mem [MAX_NODES];
	logic [NODE_W-1:0] fail_mem [MAX_NODES];
	logic [NODE_W-1:0] queue_mem [MAX_NODES];

	row_t              row_rd_q;
	logic [NODE_W-1:0] fail_rd_q;
	logic [NODE_W-1:0] q_rd_q;

	logic [2:0]        op_q;
	logic [3:0]        digit_q;
	status_t           status_q;
	logic              here_q;
	logic [CNT_W-1:0]  node_count_q;
	logic [NODE_W-1:0] cursor_q;
	logic [NODE_W-1:0] current_q;
	logic              sticky_q;
	logic              built_q;
	logic [CNT_W-1:0]  head_q;
	logic [CNT_W-1:0]  tail_q;
	logic [NODE_W-1:0] v_q;
	logic [DIG_W-1:0]  d_q;
	row_t              row_q;
	out_t              out_q;

	logic              row_re, row_we, fail_re, fail_we, q_re, q_we;
	logic [NODE_W-1:0] row_raddr, row_waddr, fail_raddr, fail_waddr, q_raddr, q_waddr;
	logic [NODE_W-1:0] fail_wdata, q_wdata;
	row_t              row_wdata;
	row_t              row_mod;
	logic [DIG_W-1:0]  dig_idx;
	logic [NODE_W-1:0] step_node;
	logic [NODE_W-1:0] child;
	logic [NODE_W-1:0] nc_node;
	logic              tail_room;
	logic [31:0]       cur_ext;

	assign dig_idx   = digit_q[DIG_W-1:0];
	assign step_node = row_rd_q.nxt[dig_idx];
	assign child     = row_q.nxt[d_q];
	assign nc_node   = node_count_q[NODE_W-1:0];
	assign tail_room = tail_q < CNT_W'(MAX_NODES);
	assign cur_ext   = 32'(current_q);

	always_comb begin
		row_re     = 1'b0;
		row_we     = 1'b0;
		fail_re    = 1'b0;
		fail_we    = 1'b0;
		q_re       = 1'b0;
		q_we       = 1'b0;
		row_raddr  = '0;
		row_waddr  = '0;
		fail_raddr = '0;
		fail_waddr = '0;
		q_raddr    = '0;
		q_waddr    = '0;
		fail_wdata = '0;
		q_wdata    = '0;
		row_wdata  = '0;
		row_mod    = row_rd_q;
		unique case (cmd.op)
			OP_INIT_ROOT, OP_CLEAR: begin
				row_we = 1'b1;
			end
			OP_RD_CURSOR: begin
				row_re    = 1'b1;
				row_raddr = cursor_q;
			end
			OP_RD_CURRENT: begin
				row_re    = 1'b1;
				row_raddr = current_q;
			end
			OP_INS_EDGE: begin
				row_mod.nxt[dig_idx] = nc_node;
				row_we    = 1'b1;
				row_waddr = cursor_q;
				row_wdata = row_mod;
			end
			OP_INS_NEW: begin
				row_we    = 1'b1;
				row_waddr = nc_node;
			end
			OP_END: begin
				row_mod.term = 1'b1;
				row_we    = 1'b1;
				row_waddr = cursor_q;
				row_wdata = row_mod;
			end
			OP_MAT_STEP: begin
				row_re    = 1'b1;
				row_raddr = step_node;
			end
			OP_BLD_START: begin
				q_we = 1'b1;
			end
			OP_BLD_POP: begin
				q_re    = 1'b1;
				q_raddr = head_q[NODE_W-1:0];
			end
			OP_BLD_V: begin
				row_re     = 1'b1;
				row_raddr  = q_rd_q;
				fail_re    = 1'b1;
				fail_raddr = q_rd_q;
			end
			OP_BLD_LK: begin
				// the root is its own failure target
				row_re    = 1'b1;
				row_raddr = (v_q == '0) ? '0 : fail_rd_q;
			end
			OP_BLD_DIGIT: begin
				if (child != '0) begin
					fail_we    = 1'b1;
					fail_waddr = child;
					fail_wdata = (v_q != '0) ? row_rd_q.nxt[d_q] : '0;
					q_we       = tail_room;
					q_waddr    = tail_q[NODE_W-1:0];
					q_wdata    = child;
				end
			end
			OP_BLD_WB: begin
				row_we    = 1'b1;
				row_waddr = v_q;
				row_wdata = row_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (row_re) begin
			row_rd_q <= row_mem[row_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (fail_we) begin
			fail_mem[fail_waddr] <= fail_wdata;
		end
		if (fail_re) begin
			fail_rd_q <= fail_mem[fail_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		if (q_re) begin
			q_rd_q <= queue_mem[q_raddr];
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				op_q     <= in_data.opcode;
				digit_q  <= in_data.digit;
				status_q <= ST_OK;
				here_q   <= 1'b0;
			end
			OP_ERROR: begin
				status_q <= cmd.st;
			end
			OP_MAT_OUT: begin
				here_q <= row_rd_q.outb;
			end
			OP_BLD_V: begin
				v_q <= q_rd_q;
			end
			OP_BLD_LK: begin
				row_q <= row_rd_q;
			end
			OP_BLD_ROW: begin
				row_q.outb <= row_q.term | ((v_q != '0) ? row_rd_q.outb : row_rd_q.term);
			end
			OP_BLD_DIGIT: begin
				if (child == '0) begin
					row_q.nxt[d_q] <= row_rd_q.nxt[d_q];
				end
			end
			OP_RESULT: begin
				out_q.status      <= status_q;
				out_q.match_here  <= here_q;
				out_q.matched_any <= sticky_q;
				out_q.node        <= cur_ext[NODE_OUT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// automaton control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(1);
			cursor_q     <= '0;
			current_q    <= '0;
			sticky_q     <= 1'b0;
			built_q      <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			d_q          <= '0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR: begin
					node_count_q <= CNT_W'(1);
					cursor_q     <= '0;
					current_q    <= '0;
					sticky_q     <= 1'b0;
					built_q      <= 1'b0;
				end
				OP_RESTART: begin
					current_q <= '0;
					sticky_q  <= 1'b0;
				end
				OP_INS_EDGE: begin
					cursor_q <= nc_node;
				end
				OP_INS_FOLLOW: begin
					cursor_q <= step_node;
				end
				OP_INS_NEW: begin
					node_count_q <= node_count_q + CNT_W'(1);
				end
				OP_END: begin
					cursor_q <= '0;
				end
				OP_MAT_STEP: begin
					current_q <= step_node;
				end
				OP_MAT_OUT: begin
					sticky_q <= sticky_q | row_rd_q.outb;
				end
				OP_BLD_START: begin
					head_q <= '0;
					tail_q <= CNT_W'(1);
				end
				OP_BLD_POP: begin
					head_q <= head_q + CNT_W'(1);
				end
				OP_BLD_DONE: begin
					built_q   <= 1'b1;
					cursor_q  <= '0;
					current_q <= '0;
					sticky_q  <= 1'b0;
				end
				OP_BLD_ROW: begin
					d_q <= '0;
				end
				OP_BLD_DIGIT: begin
					d_q <= d_q + DIG_W'(1);
					if (child != '0 && tail_room) begin
						tail_q <= tail_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.opcode     = op_q;
	assign stat.built      = built_q;
	assign stat.digit_bad  = {1'b0, digit_q} >= 5'(ALPHABET);
	assign stat.child_zero = step_node == '0;
	assign stat.full       = node_count_q >= CNT_W'(MAX_NODES);
	assign stat.bfs_more   = (head_q < tail_q) && (head_q < CNT_W'(MAX_NODES));
	assign stat.digit_last = d_q == DIG_W'(ALPHABET - 1);
	assign out_data        = out_q;

	`DPM_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, node_count_q >= CNT_W'(1) && node_count_q <= CNT_W'(MAX_NODES))
	`DPM_ASSERT_IMP(a_current_live, clk, arst_n, 1'b1, CNT_W'(current_q) < node_count_q)
	`DPM_ASSERT_IMP(a_queue_order, clk, arst_n, cmd.op == OP_BLD_DIGIT, head_q <= tail_q && tail_q <= CNT_W'(MAX_NODES))

endmodule

### rtl/dpm_ctrl.sv
// ----------------------------------------------------------------------------
// dpm_ctrl
// Sequencer for the matcher: handshakes, opcode dispatch and the build walk.
// ----------------------------------------------------------------------------
`include "digit_pattern_matcher_macros.svh"

module dpm_ctrl
	import dpm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [15:0] {
		S_INIT      = 16'h0001,
		S_IDLE      = 16'h0002,
		S_DISPATCH  = 16'h0004,
		S_INS_RD    = 16'h0008,
		S_INS_NEW   = 16'h0010,
		S_END_RD    = 16'h0020,
		S_MAT_RD    = 16'h0040,
		S_MAT_OUT   = 16'h0080,
		S_BLD_START = 16'h0100,
		S_BLD_POP   = 16'h0200,
		S_BLD_V     = 16'h0400,
		S_BLD_LK    = 16'h0800,
		S_BLD_ROW   = 16'h1000,
		S_BLD_DIGIT = 16'h2000,
		S_BLD_WB    = 16'h4000,
		S_FINISH    = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NOP;
		cmd.st  = ST_OK;
		unique case (state_q)
			S_INIT: begin
				cmd.op  = OP_INIT_ROOT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				unique case (stat.opcode)
					OPC_CLEAR: begin
						cmd.op = OP_CLEAR;
					end
					OPC_INSERT: begin
						if (stat.built) begin
							cmd.op = OP_ERROR;
							cmd.st = ST_PHASE;
						end else if (stat.digit_bad) begin
							cmd.op = OP_ERROR;
							cmd.st = ST_DIGIT;
						end else begin
							cmd.op  = OP_RD_CURSOR;
							state_d = S_INS_RD;
						end
					end
					OPC_END: begin
						if (stat.built) begin
							cmd.op = OP_ERROR;
							cmd.st = ST_PHASE;
						end else begin
							cmd.op  = OP_RD_CURSOR;
							state_d = S_END_RD;
						end
					end
					OPC_BUILD: begin
						if (stat.built) begin
							cmd.op = OP_ERROR;
							cmd.st = ST_PHASE;
						end else begin
							state_d = S_BLD_START;
						end
					end
					OPC_RESTART: begin
						cmd.op = OP_RESTART;
					end
					OPC_MATCH: begin
						if (!stat.built) begin
							cmd.op = OP_ERROR;
							cmd.st = ST_PHASE;
						end else if (stat.digit_bad) begin
							cmd.op = OP_ERROR;
							cmd.st = ST_DIGIT;
						end else begin
							cmd.op  = OP_RD_CURRENT;
							state_d = S_MAT_RD;
						end
					end
					default: begin
					end
				endcase
			end
			S_INS_RD: begin
				priority if (!stat.child_zero) begin
					cmd.op  = OP_INS_FOLLOW;
					state_d = S_FINISH;
				end else if (stat.full) begin
					cmd.op  = OP_ERROR;
					cmd.st  = ST_FULL;
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_INS_EDGE;
					state_d = S_INS_NEW;
				end
			end
			S_INS_NEW: begin
				cmd.op  = OP_INS_NEW;
				state_d = S_FINISH;
			end
			S_END_RD: begin
				cmd.op  = OP_END;
				state_d = S_FINISH;
			end
			S_MAT_RD: begin
				cmd.op  = OP_MAT_STEP;
				state_d = S_MAT_OUT;
			end
			S_MAT_OUT: begin
				cmd.op  = OP_MAT_OUT;
				state_d = S_FINISH;
			end
			S_BLD_START: begin
				cmd.op  = OP_BLD_START;
				state_d = S_BLD_POP;
			end
			S_BLD_POP: begin
				if (stat.bfs_more) begin
					cmd.op  = OP_BLD_POP;
					state_d = S_BLD_V;
				end else begin
					cmd.op  = OP_BLD_DONE;
					state_d = S_FINISH;
				end
			end
			S_BLD_V: begin
				cmd.op  = OP_BLD_V;
				state_d = S_BLD_LK;
			end
			S_BLD_LK: begin
				cmd.op  = OP_BLD_LK;
				state_d = S_BLD_ROW;
			end
			S_BLD_ROW: begin
				cmd.op  = OP_BLD_ROW;
				state_d = S_BLD_DIGIT;
			end
			S_BLD_DIGIT: begin
				cmd.op = OP_BLD_DIGIT;
				if (stat.digit_last) begin
					state_d = S_BLD_WB;
				end
			end
			S_BLD_WB: begin
				cmd.op  = OP_BLD_WB;
				state_d = S_BLD_POP;
			end
			S_FINISH: begin
				// wait here until the result register can take the item
				if (slot_free) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DPM_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, in_valid && in_ready, state_q == S_DISPATCH)
	`DPM_ASSERT_IMP(a_result_slot, clk, arst_n, cmd.op == OP_RESULT, !out_valid_q || out_ready)
	`DPM_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.op == OP_RESULT, out_valid_q && state_q == S_IDLE)

endmodule

### rtl/digit_pattern_matcher.sv
// Each item is taken in S_IDLE and decoded in S_DISPATCH; clear, restart, unknown opcodes and
// dispatch errors go to S_FINISH, end via S_END_RD, insert via S_INS_RD (plus S_INS_NEW for
// a new node), match via S_MAT_RD and S_MAT_OUT. S_FINISH waits for a free result register;
// a new item is taken while a result waits. Build walks the trie once, breadth first, reading
// each node's row and its failure target's row. Reset: all control clears at once; S_INIT then
// writes the root row before items are taken. Nodes past the fill count are never read.
// ----------------------------------------------------------------------------
// digit_pattern_matcher
// Multi-pattern digit automaton: trie load, breadth-first build, stream match.
// ----------------------------------------------------------------------------
module digit_pattern_matcher
	import dpm_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int ALPHABET  = ALPHABET_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dpm_datapath #(
		.MAX_NODES (MAX_NODES),
		.ALPHABET  (ALPHABET)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

### sim/digit_pattern_matcher_tb.sv
// ----------------------------------------------------------------------------
// digit_pattern_matcher_tb
// Loads digit patterns, builds the automaton and streams match digits through
// it under random idling on both sides, checking every result against a
// behavioral trie/failure-link model held in the bench.
// ----------------------------------------------------------------------------
module digit_pattern_matcher_tb;
	import dpm_pkg::*;

	localparam int NODES       = 1024;
	localparam int ALPH        = 10;
	localparam int LIMIT       = 3000000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	digit_pattern_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// automaton model state
	int unsigned trie_next [NODES*ALPH];
	int unsigned fail_of [NODES];
	bit          is_term [NODES];
	bit          is_out [NODES];
	int unsigned nodes_used = 1;
	int unsigned cursor = 0;
	int unsigned cur_node = 0;
	bit          seen_match = 0;
	bit          is_built = 0;

	in_t  pending_items[$];
	out_t expected_results[$];
	int   errors = 0;
	int   n_results = 0;
	int   n_hits = 0;
	int   cycle = 0;
	int   send_idle_pct, recv_stall_pct;
	bit   hold_req = 0;
	bit   hold_done = 0;
	int   hold_count = 0;
	logic hold_off_long;

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch at result %0d: %s got %0d want %0d", n_results, what, got, want);
	endtask

	function automatic void trie_clear();
		foreach (trie_next[i]) trie_next[i] = 0;
		foreach (fail_of[i]) begin
			fail_of[i] = 0;
			is_term[i] = 0;
			is_out[i] = 0;
		end
		nodes_used = 1;
		cursor = 0;
		cur_node = 0;
		seen_match = 0;
		is_built = 0;
	endfunction

	function automatic void trie_build();
		int unsigned order[$];
		int unsigned v, lk, child;
		order = {order, 32'd0};
		while (order.size() > 0) begin
			v = order.pop_front();
			lk = fail_of[v];
			is_out[v] = is_term[v] | (v != 0 ? is_out[lk] : is_term[lk]);
			for (int d = 0; d < ALPH; d++) begin
				child = trie_next[v*ALPH+d];
				if (child != 0) begin
					fail_of[child] = (v != 0) ? trie_next[lk*ALPH+d] : 0;
					order = {order, child};
				end else
					trie_next[v*ALPH+d] = trie_next[lk*ALPH+d];
			end
		end
	endfunction

	function automatic out_t predict_result(in_t it);
		out_t r;
		int unsigned e;
		r.status = ST_OK;
		r.match_here = 0;
		case (it.opcode)
			OPC_CLEAR: trie_clear();
			OPC_INSERT: begin
				if (is_built) r.status = ST_PHASE;
				else if (it.digit >= ALPH) r.status = ST_DIGIT;
				else begin
					e = cursor*ALPH + it.digit;
					if (trie_next[e] == 0 && nodes_used >= NODES) r.status = ST_FULL;
					else begin
						if (trie_next[e] == 0) begin
							trie_next[e] = nodes_used;
							nodes_used++;
						end
						cursor = trie_next[e];
					end
				end
			end
			OPC_END: begin
				if (is_built) r.status = ST_PHASE;
				else begin
					is_term[cursor] = 1;
					cursor = 0;
				end
			end
			OPC_BUILD: begin
				if (is_built) r.status = ST_PHASE;
				else begin
					trie_build();
					is_built = 1;
					cursor = 0;
					cur_node = 0;
					seen_match = 0;
				end
			end
			OPC_RESTART: begin
				cur_node = 0;
				seen_match = 0;
			end
			OPC_MATCH: begin
				if (!is_built) r.status = ST_PHASE;
				else if (it.digit >= ALPH) r.status = ST_DIGIT;
				else begin
					cur_node = trie_next[cur_node*ALPH + it.digit];
					r.match_here = is_out[cur_node];
					if (r.match_here) seen_match = 1;
				end
			end
			default: ;
		endcase
		r.matched_any = seen_match;
		r.node = cur_node[9:0];
		return r;
	endfunction

	function automatic void add_item(logic [2:0] op, logic [3:0] d);
		in_t it;
		it.opcode = op;
		it.digit = d;
		pending_items = {pending_items, it};
	endfunction

	// a small random pattern set, built, then a stream of mostly match digits mixed with other items
	function automatic void add_session(int n_pat, int max_len, int stream_len);
		add_item(OPC_CLEAR, 4'd0);
		for (int p = 0; p < n_pat; p++) begin
			int len;
			len = $urandom_range(max_len, 1);
			for (int k = 0; k < len; k++) add_item(OPC_INSERT, 4'($urandom_range(3, 0)));
			add_item(OPC_END, 4'd0);
		end
		if ($urandom_range(3, 0) == 0) add_item(OPC_INSERT, 4'($urandom_range(9, 0)));
		add_item(OPC_BUILD, 4'd0);
		for (int k = 0; k < stream_len; k++) begin
			int r;
			r = $urandom_range(99, 0);
			if (r < 85) add_item(OPC_MATCH, 4'($urandom_range(3, 0)));
			else if (r < 90) add_item(OPC_MATCH, 4'($urandom_range(9, 0)));
			else if (r < 93) add_item(OPC_MATCH, 4'($urandom_range(15, 10)));
			else if (r < 96) add_item(OPC_RESTART, 4'($urandom));
			else add_item(3'($urandom_range(7, 1)), 4'($urandom));
		end
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) expected_results = {expected_results, predict_result(in_data)};
			if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				in_valid <= 1;
				in_data <= pending_items.pop_front();
			end else
				in_valid <= 0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				out_t want;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.status != want.status)
						report_mismatch("status", out_data.status, want.status);
					if (out_data.match_here != want.match_here)
						report_mismatch("match_here", out_data.match_here, want.match_here);
					if (out_data.matched_any != want.matched_any)
						report_mismatch("matched_any", out_data.matched_any, want.matched_any);
					if (out_data.node != want.node)
						report_mismatch("node", out_data.node, want.node);
					if (want.match_here) n_hits++;
				end
				n_results++;
			end
			out_ready <= !hold_off_long && ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// long receiver hold-off, counted in its own process
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			if (hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
			else hold_done <= 1'b1;
		end
	end

	assign hold_off_long = hold_req && !hold_done;

	always @(posedge clk) begin
		cycle++;
		if (cycle > LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("digit_pattern_matcher_tb NOT OK");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_phase(int idle, int stall, int sessions);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int s = 0; s < sessions; s++)
			add_session($urandom_range(5, 1), $urandom_range(5, 1), $urandom_range(60, 20));
		wait_drained();
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed: wrong phase, bad digits, unknown opcodes, empty pattern, open pattern, double build
		add_item(OPC_MATCH, 4'd3);
		add_item(OPC_INSERT, 4'd15);
		add_item(OPC_INSERT, 4'd10);
		add_item(OPC_INSERT, 4'd9);
		add_item(OPC_INSERT, 4'd0);
		add_item(OPC_END, 4'd0);
		add_item(OPC_INSERT, 4'd0);
		add_item(3'd6, 4'd5);
		add_item(3'd7, 4'd15);
		add_item(OPC_BUILD, 4'd0);
		add_item(OPC_BUILD, 4'd0);
		add_item(OPC_INSERT, 4'd1);
		add_item(OPC_END, 4'd0);
		add_item(OPC_MATCH, 4'd9);
		add_item(OPC_MATCH, 4'd0);
		add_item(OPC_MATCH, 4'd0);
		add_item(OPC_MATCH, 4'd12);
		add_item(OPC_RESTART, 4'd7);
		add_item(OPC_CLEAR, 4'd15);
		add_item(OPC_END, 4'd0);
		add_item(OPC_BUILD, 4'd0);
		add_item(OPC_MATCH, 4'd5);
		add_item(OPC_CLEAR, 4'd0);
		wait_drained();

		// fill the node table: one long chain reaching the full status
		add_item(OPC_CLEAR, 4'd0);
		for (int k = 0; k < NODES + 1; k++) add_item(OPC_INSERT, 4'($urandom_range(9, 0)));
		add_item(OPC_END, 4'd0);
		add_item(OPC_BUILD, 4'd0);
		for (int k = 0; k < 10; k++) add_item(OPC_MATCH, 4'($urandom_range(9, 0)));
		wait_drained();

		run_phase(0, 0, 2);
		run_phase(82, 0, 1);
		run_phase(0, 82, 1);
		run_phase(28, 28, 2);

		// long receiver hold-off while items keep coming
		hold_req = 1;
		add_session(3, 4, 40);
		wait (hold_done);
		wait_drained();

		$display("results checked: %0d, match hits: %0d", n_results, n_hits);
		$display("covered directed errors, full node table, and random load/build/match sessions");
		if (errors == 0)
			$display("digit_pattern_matcher_tb OK");
		else
			$display("digit_pattern_matcher_tb NOT OK");
		$finish;
	end
endmodule
